// File: rtl/esa_pkg.sv
// Package for the element stiffness accumulator: sizes, codes, types and arithmetic helpers.
`default_nettype none
package esa_pkg;

    localparam int MAX_DOFS          = 16;
    localparam int STRESS_COMPONENTS = 3;

    localparam int B_DEPTH  = STRESS_COMPONENTS * MAX_DOFS;
    localparam int D_DEPTH  = STRESS_COMPONENTS * STRESS_COMPONENTS;
    localparam int DB_DEPTH = STRESS_COMPONENTS * MAX_DOFS;
    localparam int K_DEPTH  = MAX_DOFS * MAX_DOFS;

    localparam int BA_W  = $clog2(B_DEPTH);
    localparam int DA_W  = $clog2(D_DEPTH);
    localparam int DBA_W = $clog2(DB_DEPTH);
    localparam int KA_W  = $clog2(K_DEPTH);
    localparam int DOF_W = $clog2(MAX_DOFS);
    localparam int CT_W  = $clog2(STRESS_COMPONENTS);
    localparam int POS_W = 6;
    localparam int CFG_W = 5;

    // item operation codes
    localparam logic [1:0] OP_DATA  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DB,
        PH_K
    } t_phase;

    // start request from the item controller to the engine
    typedef struct packed {
        logic             start;
        logic [CFG_W-1:0] n;
    } t_eng_ctl;

    // memory requests from the engine
    typedef struct packed {
        logic [BA_W-1:0]    b_raddr;
        logic [DA_W-1:0]    d_raddr;
        logic [DBA_W-1:0]   db_raddr;
        logic               db_we;
        logic [DBA_W-1:0]   db_waddr;
        logic signed [31:0] db_wdata;
        logic [KA_W-1:0]    k_raddr;
        logic               k_we;
        logic [KA_W-1:0]    k_waddr;
        logic signed [63:0] k_wdata;
    } t_eng_mem;

    // saturating 64-bit add
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    // Q32.32 sum to Q16.16: round half up, saturate to 32 bits
    function automatic logic signed [31:0] round_sat32(input logic signed [65:0] v);
        logic signed [65:0] r;
        logic signed [49:0] q;
        r = v + 66'sd32768;
        q = r[65:16];
        if (q > 50'sd2147483647) begin
            round_sat32 = {1'b0, {31{1'b1}}};
        end else if (q < -50'sd2147483648) begin
            round_sat32 = {1'b1, 31'd0};
        end else begin
            round_sat32 = q[31:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: rtl/esa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module esa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/esa_engine.sv
// Point engine: D*B pass then B^T*(DB) pass into K, one shared multiplier, pipelined.
`default_nettype none
module esa_engine (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire esa_pkg::t_eng_ctl         i_ctl,
    input  wire logic signed [31:0]        i_b_rdata,
    input  wire logic signed [31:0]        i_d_rdata,
    input  wire logic signed [31:0]        i_db_rdata,
    input  wire logic signed [63:0]        i_k_rdata,
    output esa_pkg::t_eng_mem              o_mem,
    output logic                           o_done
);
    import esa_pkg::*;

    t_phase            r_phase, n_phase;
    logic              r_issue, n_issue;
    logic [DOF_W-1:0]  r_ca, n_ca, r_cb, n_cb;
    logic [CT_W-1:0]   r_ct, n_ct;
    logic [CFG_W-1:0]  r_n;

    logic [DOF_W-1:0]  w_nm1, w_ca_lim;
    logic [BA_W-1:0]   w_b_row;

    logic              r_v1, r_first1, r_last1;
    logic [KA_W-1:0]   r_tag1;
    logic              r_v2, r_first2, r_last2;
    logic [KA_W-1:0]   r_tag2;
    logic signed [63:0] r_p2, r_kin2;
    logic signed [65:0] r_acc, w_sum, r_tot3;
    logic              r_v3;
    logic [KA_W-1:0]   r_tag3;
    logic signed [63:0] r_kacc, w_ksum;
    logic signed [31:0] w_opa, w_opb;

    assign w_nm1    = DOF_W'(r_n - CFG_W'(1));
    assign w_ca_lim = (r_phase == PH_DB) ? DOF_W'(STRESS_COMPONENTS - 1) : w_nm1;

    // loop counters: (s, j, t) in the D*B pass, (i, j, s) in the K pass
    always_comb begin
        n_phase = r_phase;
        n_issue = r_issue;
        n_ca    = r_ca;
        n_cb    = r_cb;
        n_ct    = r_ct;
        o_done  = 1'b0;
        if (i_ctl.start) begin
            n_phase = PH_DB;
            n_issue = 1'b1;
            n_ca    = '0;
            n_cb    = '0;
            n_ct    = '0;
        end else if (r_issue) begin
            if (r_ct != CT_W'(STRESS_COMPONENTS - 1)) begin
                n_ct = r_ct + CT_W'(1);
            end else begin
                n_ct = '0;
                if (r_cb != w_nm1) begin
                    n_cb = r_cb + DOF_W'(1);
                end else begin
                    n_cb = '0;
                    if (r_ca != w_ca_lim) begin
                        n_ca = r_ca + DOF_W'(1);
                    end else begin
                        n_ca    = '0;
                        n_issue = 1'b0;
                    end
                end
            end
        end else if (r_phase != PH_IDLE && !r_v1 && !r_v2 && !r_v3) begin
            // pipeline drained
            if (r_phase == PH_DB) begin
                n_phase = PH_K;
                n_issue = 1'b1;
            end else begin
                n_phase = PH_IDLE;
                o_done  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_issue <= 1'b0;
            r_ca    <= '0;
            r_cb    <= '0;
            r_ct    <= '0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_issue <= n_issue;
            r_ca    <= n_ca;
            r_cb    <= n_cb;
            r_ct    <= n_ct;
            r_v1    <= r_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2 && r_last2 && (r_phase == PH_DB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_n <= i_ctl.n;
        end
    end

    assign w_b_row = BA_W'(r_ct) * BA_W'(r_n);

    // stage 1: read data arriving
    always_ff @(posedge i_clk) begin
        r_first1 <= (r_ct == '0);
        r_last1  <= (r_ct == CT_W'(STRESS_COMPONENTS - 1));
        r_tag1   <= {r_ca, r_cb};
    end

    // stage 2: product register
    assign w_opa = (r_phase == PH_DB) ? i_d_rdata : i_b_rdata;
    assign w_opb = (r_phase == PH_DB) ? i_b_rdata : i_db_rdata;
    always_ff @(posedge i_clk) begin
        r_first2 <= r_first1;
        r_last2  <= r_last1;
        r_tag2   <= r_tag1;
        r_p2     <= w_opa * w_opb;
        r_kin2   <= i_k_rdata;
    end

    // stage 3: exact sum for D*B, saturating accumulate for K
    assign w_sum  = (r_first2 ? 66'sd0 : r_acc) + 66'(r_p2);
    assign w_ksum = sat_add64(r_first2 ? r_kin2 : r_kacc, r_p2);
    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc  <= w_sum;
            r_kacc <= w_ksum;
        end
        r_tot3 <= w_sum;
        r_tag3 <= r_tag2;
    end

    // read addresses and write-backs
    always_comb begin
        o_mem.b_raddr  = w_b_row + BA_W'((r_phase == PH_DB) ? r_cb : r_ca);
        o_mem.d_raddr  = DA_W'(r_ca) * DA_W'(STRESS_COMPONENTS) + DA_W'(r_ct);
        o_mem.db_raddr = DBA_W'(r_ct) * DBA_W'(MAX_DOFS) + DBA_W'(r_cb);
        o_mem.k_raddr  = {r_ca, r_cb};
        o_mem.k_we     = r_v2 && r_last2 && (r_phase == PH_K);
        o_mem.k_waddr  = r_tag2;
        o_mem.k_wdata  = w_ksum;
        o_mem.db_we    = r_v3;
        o_mem.db_waddr = r_tag3[DBA_W-1:0];
        o_mem.db_wdata = round_sat32(r_tot3);
    end

endmodule
`default_nettype wire

// File: rtl/element_stiffness_accumulator.sv
// Top level of the element stiffness accumulator: item control, memories and engine.
//
// channel  | dir | handshake               | payload
// s_axis   | in  | tvalid/tready           | tuser: op; tdata: value, row, col
// m_axis   | out | tvalid/tready           | tdata: k_entry
// cfg      | in  | we                      | wdata: num_dofs
//
// Data and clear items take effect as they are accepted. A read item goes through the K RAM
// read register, then ST_READ loads the output register. The last D item of a point starts
// the engine: a D*B pass, then a K pass, each drained, through the single multiplier.
// Reset is synchronous; K reads as zero after reset and clear through per-entry valid bits.
// The output register holds a result until taken; no item is accepted while it is full
// and not being taken.
`default_nettype none
module element_stiffness_accumulator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,   // value[31:0], row[35:32], col[39:36]
    input  wire logic [1:0]  i_s_axis_tuser,   // op[1:0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,   // k_entry[63:0]
    input  wire logic        i_cfg_we,
    input  wire logic [esa_pkg::CFG_W-1:0] i_cfg_wdata
);
    import esa_pkg::*;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [POS_W-1:0]   r_pos;
    logic [K_DEPTH-1:0] r_kvalid;
    logic               r_kv_rd;
    logic               r_ovalid;
    logic [63:0]        r_odata;

    logic               w_accept;
    logic [1:0]         w_op;
    logic signed [31:0] w_value;
    logic [DOF_W-1:0]   w_row, w_col;
    logic [CFG_W-1:0]   w_n;
    logic [POS_W-1:0]   w_nb, w_len, w_pos, w_pos_inc;
    logic               w_data, w_last, w_b_we, w_d_we, w_clear;

    t_eng_ctl           w_ctl;
    t_eng_mem           w_mem;
    logic               w_done;
    logic [31:0]        w_b_rdata, w_d_rdata, w_db_rdata;
    logic [63:0]        w_k_rdata, w_k_masked;
    logic [KA_W-1:0]    w_k_raddr;

    assign w_op    = i_s_axis_tuser;
    assign w_value = i_s_axis_tdata[31:0];
    assign w_row   = i_s_axis_tdata[35:32];
    assign w_col   = i_s_axis_tdata[39:36];

    // handshake
    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // effective dof count and position within the point
    assign w_n = (r_cfg == '0) ? CFG_W'(1) :
                 (r_cfg > CFG_W'(MAX_DOFS)) ? CFG_W'(MAX_DOFS) : r_cfg;
    assign w_nb      = POS_W'(STRESS_COMPONENTS) * POS_W'(w_n);
    assign w_len     = w_nb + POS_W'(D_DEPTH);
    assign w_pos     = (r_pos >= w_len) ? '0 : r_pos;
    assign w_pos_inc = w_pos + POS_W'(1);

    assign w_data  = w_accept && (w_op == OP_DATA);
    assign w_clear = w_accept && (w_op == OP_CLEAR);
    assign w_b_we  = w_data && (w_pos < w_nb);
    assign w_d_we  = w_data && (w_pos >= w_nb);
    assign w_last  = w_d_we && (w_pos_inc == w_len);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_last) begin
                    n_state = ST_CALC;
                end else if (w_accept && w_op == OP_READ) begin
                    n_state = ST_READ;
                end
            end
            ST_CALC: begin
                if (w_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_W'(8);
            r_pos <= '0;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
            r_pos <= '0;
        end else if (w_clear || w_last) begin
            r_pos <= '0;
        end else if (w_data) begin
            r_pos <= w_pos_inc;
        end
    end

    // K valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kvalid <= '0;
        end else if (w_clear) begin
            r_kvalid <= '0;
        end else if (w_mem.k_we) begin
            r_kvalid[w_mem.k_waddr] <= 1'b1;
        end
    end

    assign w_k_raddr = (r_state == ST_CALC) ? w_mem.k_raddr : {w_row, w_col};
    always_ff @(posedge i_clk) begin
        r_kv_rd <= r_kvalid[w_k_raddr];
    end
    assign w_k_masked = r_kv_rd ? w_k_rdata : 64'd0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_READ) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_odata <= w_k_masked;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // engine
    assign w_ctl = {w_last, w_n};

    esa_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_b_rdata  (w_b_rdata),
        .i_d_rdata  (w_d_rdata),
        .i_db_rdata (w_db_rdata),
        .i_k_rdata  (w_k_masked),
        .o_mem      (w_mem),
        .o_done     (w_done)
    );

    // memories
    esa_ram #(.WIDTH(32), .DEPTH(B_DEPTH)) u_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_pos[BA_W-1:0]),
        .i_wdata (w_value),
        .i_raddr (w_mem.b_raddr),
        .o_rdata (w_b_rdata)
    );

    esa_ram #(.WIDTH(32), .DEPTH(D_DEPTH)) u_d_ram (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (DA_W'(w_pos - w_nb)),
        .i_wdata (w_value),
        .i_raddr (w_mem.d_raddr),
        .o_rdata (w_d_rdata)
    );

    esa_ram #(.WIDTH(32), .DEPTH(DB_DEPTH)) u_db_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.db_we),
        .i_waddr (w_mem.db_waddr),
        .i_wdata (w_mem.db_wdata),
        .i_raddr (w_mem.db_raddr),
        .o_rdata (w_db_rdata)
    );

    esa_ram #(.WIDTH(64), .DEPTH(K_DEPTH)) u_k_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.k_we),
        .i_waddr (w_mem.k_waddr),
        .i_wdata (w_mem.k_wdata),
        .i_raddr (w_k_raddr),
        .o_rdata (w_k_rdata)
    );

endmodule
`default_nettype wire
